@@ hw/rtl/polygon_area_perimeter_core_defines.svh @@
// ----------------------------------------------------------------------------
// polygon_area_perimeter_core_defines.svh
// Assertion macros shared by the polygon area/perimeter core.
// ----------------------------------------------------------------------------
`ifndef POLYGON_AREA_PERIMETER_CORE_DEFINES_SVH
`define POLYGON_AREA_PERIMETER_CORE_DEFINES_SVH

// same-cycle implication
`define PAPC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PAPC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/papc_pkg.sv @@
// ----------------------------------------------------------------------------
// papc_pkg
// Types and constants of the polygon area/perimeter core.
// ----------------------------------------------------------------------------
package papc_pkg;

   localparam int IN_COORD_BITS  = 16;
   localparam int MAX_COORD_BITS = 24;
   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam int AREA_BITS      = 52;
   localparam int PERIM_BITS     = 40;
   localparam int COUNT_BITS     = 16;

   typedef struct packed {
      logic signed [IN_COORD_BITS-1:0] x_coord;
      logic signed [IN_COORD_BITS-1:0] y_coord;
      logic                            last_vertex;
   } req_word_type;

   typedef struct packed {
      logic [PERIM_BITS-1:0] twice_area;
      logic [PERIM_BITS-1:0] perimeter_q8;
      logic [COUNT_BITS-1:0] vertex_count;
      logic                  overflowed;
   } rsp_word_type;

   // one edge a -> b, coordinates sign-extended to the widest supported size
   typedef struct packed {
      logic signed [MAX_COORD_BITS-1:0] ax;
      logic signed [MAX_COORD_BITS-1:0] ay;
      logic signed [MAX_COORD_BITS-1:0] bx;
      logic signed [MAX_COORD_BITS-1:0] by;
      logic                             close_edge;
      logic [COUNT_BITS-1:0]            count;
      logic                             count_ovf;
   } edge_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic {
      F_TAKE,
      F_CLOSE
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_MUL,
      B_PREP,
      B_ROOT,
      B_ACC,
      B_DONE
   } back_state_type;

endpackage

@@ hw/rtl/papc_front.sv @@
// ----------------------------------------------------------------------------
// papc_front
// Takes vertices, tracks first/previous vertex and count, emits edge jobs.
// ----------------------------------------------------------------------------
module papc_front #(
   parameter int COORD_BITS = papc_pkg::COORD_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  papc_pkg::req_word_type      req_word,
   input  papc_pkg::queue_status_type  queue_status,
   output logic                        push,
   output papc_pkg::edge_type          push_word
);

   localparam int MCB = papc_pkg::MAX_COORD_BITS;
   localparam int CB  = papc_pkg::COUNT_BITS;

   papc_pkg::front_state_type state_ff, state_in;
   logic signed [COORD_BITS-1:0] first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [COORD_BITS-1:0] prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                         have_ff, have_in;
   logic [CB-1:0]                count_ff, count_in;
   logic                         cnt_ovf_ff, cnt_ovf_in;

   logic [MCB-1:0]               xw, yw;
   logic signed [COORD_BITS-1:0] cx, cy;
   logic                         accept;
   logic                         count_sat;
   logic [CB-1:0]                count_next;
   logic                         ovf_next;

   // low COORD_BITS of the 16-bit field, sign taken from bit COORD_BITS-1
   assign xw = MCB'($unsigned(req_word.x_coord));
   assign yw = MCB'($unsigned(req_word.y_coord));
   assign cx = xw[COORD_BITS-1:0];
   assign cy = yw[COORD_BITS-1:0];

   assign req_stall  = (state_ff != papc_pkg::F_TAKE) || queue_status.full;
   assign accept     = req_valid && !req_stall;
   assign count_sat  = (count_ff == {CB{1'b1}});
   assign count_next = count_sat ? count_ff : count_ff + CB'(1);
   assign ovf_next   = cnt_ovf_ff || count_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= papc_pkg::F_TAKE;
         have_ff    <= 1'b0;
         count_ff   <= '0;
         cnt_ovf_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         have_ff    <= have_in;
         count_ff   <= count_in;
         cnt_ovf_ff <= cnt_ovf_in;
      end
      first_x_ff <= first_x_in;
      first_y_ff <= first_y_in;
      prev_x_ff  <= prev_x_in;
      prev_y_ff  <= prev_y_in;
   end

   always_comb begin
      state_in   = state_ff;
      first_x_in = first_x_ff;
      first_y_in = first_y_ff;
      prev_x_in  = prev_x_ff;
      prev_y_in  = prev_y_ff;
      have_in    = have_ff;
      count_in   = count_ff;
      cnt_ovf_in = cnt_ovf_ff;
      push       = 1'b0;
      push_word  = '0;
      case (state_ff)
         papc_pkg::F_TAKE: begin
            if (accept) begin
               count_in   = count_next;
               cnt_ovf_in = ovf_next;
               prev_x_in  = cx;
               prev_y_in  = cy;
               if (!have_ff) begin
                  first_x_in = cx;
                  first_y_in = cy;
                  have_in    = 1'b1;
               end
               if (have_ff) begin
                  push         = 1'b1;
                  push_word.ax = MCB'(prev_x_ff);
                  push_word.ay = MCB'(prev_y_ff);
                  push_word.bx = MCB'(cx);
                  push_word.by = MCB'(cy);
               end
               if (req_word.last_vertex) begin
                  if (!have_ff) begin
                     // lone vertex: zero-length closing edge onto itself
                     push                 = 1'b1;
                     push_word.ax         = MCB'(cx);
                     push_word.ay         = MCB'(cy);
                     push_word.bx         = MCB'(cx);
                     push_word.by         = MCB'(cy);
                     push_word.close_edge = 1'b1;
                     push_word.count      = count_next;
                     push_word.count_ovf  = ovf_next;
                     have_in              = 1'b0;
                     count_in             = '0;
                     cnt_ovf_in           = 1'b0;
                  end else begin
                     state_in = papc_pkg::F_CLOSE;
                  end
               end
            end
         end
         papc_pkg::F_CLOSE: begin
            if (!queue_status.full) begin
               push                 = 1'b1;
               push_word.ax         = MCB'(prev_x_ff);
               push_word.ay         = MCB'(prev_y_ff);
               push_word.bx         = MCB'(first_x_ff);
               push_word.by         = MCB'(first_y_ff);
               push_word.close_edge = 1'b1;
               push_word.count      = count_ff;
               push_word.count_ovf  = cnt_ovf_ff;
               have_in              = 1'b0;
               count_in             = '0;
               cnt_ovf_in           = 1'b0;
               state_in             = papc_pkg::F_TAKE;
            end
         end
         default: begin
            state_in = papc_pkg::F_TAKE;
         end
      endcase
   end

endmodule

@@ hw/rtl/papc_queue.sv @@
// ----------------------------------------------------------------------------
// papc_queue
// Short FIFO of edge jobs between the front and back parts.
// ----------------------------------------------------------------------------
module papc_queue #(
   parameter int DEPTH = papc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  papc_pkg::edge_type          push_word,
   input  logic                        pop,
   output papc_pkg::edge_type          head_word,
   output papc_pkg::queue_status_type  queue_status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LW = $clog2(DEPTH + 1);

   papc_pkg::edge_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   assign head_word          = mem_ff[rd_ptr_ff];
   assign queue_status.full  = (level_ff == LW'(DEPTH));
   assign queue_status.empty = (level_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

@@ hw/rtl/papc_back.sv @@
// ----------------------------------------------------------------------------
// papc_back
// Per edge: shoelace term, squared length, bit-serial root, running sums.
// ----------------------------------------------------------------------------
module papc_back #(
   parameter int COORD_BITS = papc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = papc_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  papc_pkg::edge_type          head_word,
   input  papc_pkg::queue_status_type  queue_status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output papc_pkg::rsp_word_type      rsp_word
);

   localparam int DW    = COORD_BITS + 1;
   localparam int PW    = 2 * DW;
   localparam int RADW  = PW + 2 * FRAC_BITS;
   localparam int ROOTW = RADW / 2;
   localparam int REMW  = ROOTW + 2;
   localparam int ITW   = $clog2(ROOTW);
   localparam int AW    = papc_pkg::AREA_BITS;
   localparam int SW    = AW + 1;
   localparam int PRW   = papc_pkg::PERIM_BITS;
   localparam int PSW   = PRW + 1;
   localparam int CB    = papc_pkg::COUNT_BITS;

   papc_pkg::back_state_type state_ff, state_in;
   logic signed [DW-1:0]   dx_ff, dx_in, dy_ff, dy_in, sy_ff, sy_in;
   logic signed [PW-1:0]   sqx_ff, sqx_in, sqy_ff, sqy_in, term_ff, term_in;
   logic [RADW-1:0]        rad_ff, rad_in;
   logic [REMW-1:0]        rem_ff, rem_in;
   logic [ROOTW-1:0]       root_ff, root_in;
   logic [ITW-1:0]         iter_ff, iter_in;
   logic                   close_ff, close_in;
   logic [CB-1:0]          count_ff, count_in;
   logic                   cnt_ovf_ff, cnt_ovf_in;
   logic signed [AW-1:0]   area_ff, area_in;
   logic [PRW-1:0]         perim_ff, perim_in;
   logic                   ovf_ff, ovf_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   papc_pkg::rsp_word_type rsp_word_ff, rsp_word_in;

   logic signed [COORD_BITS-1:0] hax, hay, hbx, hby;
   logic [PW-1:0]          d2;
   logic [REMW-1:0]        rem_sh, trial;
   logic signed [SW-1:0]   area_s;
   logic [PSW-1:0]         perim_s;
   logic [AW-1:0]          mag;
   logic                   mag_clamp;

   assign hax = head_word.ax[COORD_BITS-1:0];
   assign hay = head_word.ay[COORD_BITS-1:0];
   assign hbx = head_word.bx[COORD_BITS-1:0];
   assign hby = head_word.by[COORD_BITS-1:0];

   assign d2      = $unsigned(sqx_ff) + $unsigned(sqy_ff);
   assign rem_sh  = {rem_ff[REMW-3:0], rad_ff[RADW-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign area_s  = SW'(area_ff) + SW'(term_ff);
   assign perim_s = PSW'(perim_ff) + PSW'(root_ff);
   assign mag     = area_ff[AW-1] ? $unsigned(-area_ff) : $unsigned(area_ff);
   assign mag_clamp = |mag[AW-1:PRW];

   assign pop       = (state_ff == papc_pkg::B_IDLE) && !queue_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= papc_pkg::B_IDLE;
         area_ff      <= '0;
         perim_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         area_ff      <= area_in;
         perim_ff     <= perim_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      sy_ff       <= sy_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      term_ff     <= term_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      iter_ff     <= iter_in;
      close_ff    <= close_in;
      count_ff    <= count_in;
      cnt_ovf_ff  <= cnt_ovf_in;
      rsp_word_ff <= rsp_word_in;
   end

   always_comb begin
      state_in     = state_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      sy_in        = sy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      term_in      = term_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      iter_in      = iter_ff;
      close_in     = close_ff;
      count_in     = count_ff;
      cnt_ovf_in   = cnt_ovf_ff;
      area_in      = area_ff;
      perim_in     = perim_ff;
      ovf_in       = ovf_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         papc_pkg::B_IDLE: begin
            if (!queue_status.empty) begin
               dx_in      = DW'(hax) - DW'(hbx);
               dy_in      = DW'(hay) - DW'(hby);
               sy_in      = DW'(hay) + DW'(hby);
               close_in   = head_word.close_edge;
               count_in   = head_word.count;
               cnt_ovf_in = head_word.count_ovf;
               state_in   = papc_pkg::B_MUL;
            end
         end
         papc_pkg::B_MUL: begin
            sqx_in   = dx_ff * dx_ff;
            sqy_in   = dy_ff * dy_ff;
            term_in  = sy_ff * dx_ff;
            state_in = papc_pkg::B_PREP;
         end
         papc_pkg::B_PREP: begin
            // fraction bits come from extra radicand digit pairs
            rad_in   = RADW'(d2) << (2 * FRAC_BITS);
            rem_in   = '0;
            root_in  = '0;
            iter_in  = ITW'(ROOTW - 1);
            state_in = papc_pkg::B_ROOT;
         end
         papc_pkg::B_ROOT: begin
            rad_in = rad_ff << 2;
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOTW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOTW-2:0], 1'b0};
            end
            if (iter_ff == '0) begin
               state_in = papc_pkg::B_ACC;
            end else begin
               iter_in = iter_ff - ITW'(1);
            end
         end
         papc_pkg::B_ACC: begin
            if (area_s[SW-1] != area_s[SW-2]) begin
               area_in = area_s[SW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
               ovf_in  = 1'b1;
            end else begin
               area_in = area_s[AW-1:0];
            end
            if (perim_s[PRW]) begin
               perim_in = {PRW{1'b1}};
               ovf_in   = 1'b1;
            end else begin
               perim_in = perim_s[PRW-1:0];
            end
            state_in = close_ff ? papc_pkg::B_DONE : papc_pkg::B_IDLE;
         end
         papc_pkg::B_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_word_in.twice_area   = mag_clamp ? {PRW{1'b1}} : mag[PRW-1:0];
               rsp_word_in.perimeter_q8 = perim_ff;
               rsp_word_in.vertex_count = count_ff;
               rsp_word_in.overflowed   = ovf_ff || cnt_ovf_ff || mag_clamp;
               rsp_valid_in             = 1'b1;
               area_in                  = '0;
               perim_in                 = '0;
               ovf_in                   = 1'b0;
               state_in                 = papc_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = papc_pkg::B_IDLE;
         end
      endcase
   end

endmodule

@@ hw/rtl/polygon_area_perimeter_core.sv @@
// ----------------------------------------------------------------------------
// polygon_area_perimeter_core
// Streams polygon vertices, returns twice the area, perimeter and count.
// Each edge runs through the back part's states MUL, PREP, ROOT and ACC; ROOT
// is the bit-serial square root, one result bit per cycle for ROOTW bits.
// Closing vertex: its own edge, then the closing edge, then the result in DONE.
// Reset (synchronous): empty polygon, zero sums, queue empty, no result.
// ----------------------------------------------------------------------------
`include "polygon_area_perimeter_core_defines.svh"

module polygon_area_perimeter_core #(
   parameter int COORD_BITS  = papc_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS   = papc_pkg::FRAC_BITS_DEF,
   parameter int QUEUE_DEPTH = papc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  papc_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output papc_pkg::rsp_word_type  rsp_word
);

   logic                       push;
   logic                       pop;
   papc_pkg::edge_type         push_word;
   papc_pkg::edge_type         head_word;
   papc_pkg::queue_status_type queue_status;

   papc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .queue_status (queue_status),
      .push         (push),
      .push_word    (push_word)
   );

   papc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_word    (push_word),
      .pop          (pop),
      .head_word    (head_word),
      .queue_status (queue_status)
   );

   papc_back #(
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head_word    (head_word),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word)
   );

   `PAPC_ASSERT_NOW(a_no_push_full, clock, reset, push, !queue_status.full, "edge pushed into full queue")
   `PAPC_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !queue_status.empty, "edge popped from empty queue")
   `PAPC_ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !queue_status.empty, "queue empty after push")

endmodule
